[hdl/assert_macros.svh]
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/ibus_pkg.sv]
// Shared types and constants for the iBUS frame receiver
package ibus_pkg;

    localparam int NUM_CHANNELS = 14;
    localparam int CH_IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    localparam logic [4:0] POS_HDR2    = 5'd1;
    localparam logic [4:0] POS_CH_FIRST = 5'd2;
    localparam logic [4:0] POS_CH_ODD0 = 5'd3;
    localparam logic [4:0] POS_SUM_END = 5'd30;
    localparam logic [4:0] POS_LAST    = 5'd31;

    localparam logic [15:0] SUM_INIT  = 16'hFFFF;
    localparam logic [15:0] CHAN_MASK = 16'h0FFF;

    localparam logic [7:0] SYNC_FIRST_RST  = 8'h20;
    localparam logic [7:0] SYNC_SECOND_RST = 8'h40;

    // register index taken from paddr[2]
    localparam logic REG_SYNC_FIRST  = 1'b0;
    localparam logic REG_SYNC_SECOND = 1'b1;

    typedef enum logic [1:0] {
        KIND_CHAN    = 2'd0,
        KIND_HDR_ERR = 2'd1,
        KIND_SUM_ERR = 2'd2
    } t_kind;

    typedef logic [NUM_CHANNELS-1:0][11:0] t_chan_arr;

    typedef struct packed {
        logic        valid;
        t_kind       kind;
        logic [15:0] good;
        logic [15:0] bad;
    } t_frame_evt;

endpackage

[hdl/ibus_cfg.sv]
// APB register block holding the two header bytes
module ibus_cfg import ibus_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [7:0]  o_sync_first,
    output logic [7:0]  o_sync_second
);

    logic [7:0] r_sync_first;
    logic [7:0] r_sync_second;
    logic       w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first  <= SYNC_FIRST_RST;
            r_sync_second <= SYNC_SECOND_RST;
        end else if (w_wr) begin
            unique case (paddr[2])
                REG_SYNC_FIRST:  r_sync_first  <= pwdata[7:0];
                REG_SYNC_SECOND: r_sync_second <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_SYNC_FIRST:  prdata = {24'h0, r_sync_first};
            REG_SYNC_SECOND: prdata = {24'h0, r_sync_second};
            default:         prdata = 32'h0;
        endcase
    end

    assign o_sync_first  = r_sync_first;
    assign o_sync_second = r_sync_second;

endmodule

[hdl/ibus_parser.sv]
// Byte-wise frame parser: header hunt, checksum, channel store and counters
module ibus_parser import ibus_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_byte,
    input  logic [7:0]  i_sync_first,
    input  logic [7:0]  i_sync_second,
    output logic        o_frame_end,
    output t_frame_evt  o_evt,
    output t_chan_arr   o_store
);

    logic        r_in_frame, n_in_frame;
    logic [4:0]  r_pos, n_pos;
    logic        r_hdr_ok, n_hdr_ok;
    logic [15:0] r_sum, n_sum;
    logic [7:0]  r_low, n_low;
    logic [15:0] r_good, n_good;
    logic [15:0] r_bad, n_bad;
    t_chan_arr   r_store;

    logic [4:0]  w_slot_full;
    logic [3:0]  w_slot;
    logic        w_store_wr;
    logic [15:0] w_pair;

    assign w_slot_full = 5'(r_pos - POS_CH_ODD0);
    assign w_slot      = w_slot_full[4:1];
    assign w_pair      = {i_byte, r_low};

    always_comb begin
        n_in_frame = r_in_frame;
        n_pos      = r_pos;
        n_hdr_ok   = r_hdr_ok;
        n_sum      = r_sum;
        n_low      = r_low;
        n_good     = r_good;
        n_bad      = r_bad;
        w_store_wr = 1'b0;
        o_evt      = '0;
        if (i_accept) begin
            if (!r_in_frame) begin
                if (i_byte == i_sync_first) begin
                    n_in_frame = 1'b1;
                    n_pos      = POS_HDR2;
                    n_hdr_ok   = 1'b1;
                    n_sum      = SUM_INIT - {8'h0, i_byte};
                    n_low      = 8'h0;
                end
            end else begin
                if (r_pos < POS_SUM_END) begin
                    n_sum = r_sum - {8'h0, i_byte};
                end
                if (r_pos == POS_HDR2) begin
                    n_hdr_ok = (i_byte == i_sync_second);
                end else if (r_pos >= POS_CH_FIRST && r_pos < POS_SUM_END) begin
                    if (!r_pos[0]) begin
                        n_low = i_byte;
                    end else begin
                        w_store_wr = (w_slot < 4'(NUM_CHANNELS));
                    end
                end else if (r_pos == POS_SUM_END) begin
                    n_low = i_byte;
                end
                if (r_pos != POS_LAST) begin
                    n_pos = r_pos + 5'd1;
                end else begin
                    // closing byte: judge the frame
                    n_in_frame  = 1'b0;
                    n_pos       = 5'd0;
                    o_evt.valid = 1'b1;
                    if (!r_hdr_ok) begin
                        n_bad      = r_bad + 16'd1;
                        o_evt.kind = KIND_HDR_ERR;
                    end else if (r_sum != w_pair) begin
                        n_bad      = r_bad + 16'd1;
                        o_evt.kind = KIND_SUM_ERR;
                    end else begin
                        n_good     = r_good + 16'd1;
                        o_evt.kind = KIND_CHAN;
                    end
                    o_evt.good = n_good;
                    o_evt.bad  = n_bad;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_pos      <= 5'd0;
            r_hdr_ok   <= 1'b0;
            r_sum      <= SUM_INIT;
            r_low      <= 8'h0;
            r_good     <= 16'h0;
            r_bad      <= 16'h0;
        end else begin
            r_in_frame <= n_in_frame;
            r_pos      <= n_pos;
            r_hdr_ok   <= n_hdr_ok;
            r_sum      <= n_sum;
            r_low      <= n_low;
            r_good     <= n_good;
            r_bad      <= n_bad;
        end
    end

    // channel store: written before read in every frame, so no reset
    always_ff @(posedge i_clk) begin
        if (w_store_wr) begin
            r_store[w_slot[CH_IDX_W-1:0]] <= 12'(w_pair & CHAN_MASK);
        end
    end

    assign o_frame_end = r_in_frame && (r_pos == POS_LAST);
    assign o_store     = r_store;

endmodule

[hdl/ibus_emitter.sv]
// Result register: holds a frame's run, one item out per ready cycle
module ibus_emitter import ibus_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_frame_evt  i_evt,
    input  t_chan_arr   i_store,
    input  logic        i_ready,
    output logic        o_busy,
    output logic        o_valid,
    output logic [1:0]  o_kind,
    output logic [3:0]  o_index,
    output logic [11:0] o_value,
    output logic        o_last,
    output logic [15:0] o_good,
    output logic [15:0] o_bad
);

    logic [3:0]  r_left;
    logic [3:0]  r_idx;
    t_kind       r_kind;
    logic [15:0] r_good;
    logic [15:0] r_bad;
    t_chan_arr   r_vals;
    logic        w_pop;

    assign o_valid = (r_left != 4'd0);
    assign w_pop   = o_valid && i_ready;
    assign o_busy  = o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 4'd0;
            r_idx  <= 4'd0;
        end else if (i_evt.valid) begin
            r_left <= (i_evt.kind == KIND_CHAN) ? 4'(NUM_CHANNELS) : 4'd1;
            r_idx  <= 4'd0;
        end else if (w_pop) begin
            r_left <= r_left - 4'd1;
            r_idx  <= r_idx + 4'd1;
        end
    end

    // payload copy of the frame, taken while the parser starts the next one
    always_ff @(posedge i_clk) begin
        if (i_evt.valid) begin
            r_kind <= i_evt.kind;
            r_good <= i_evt.good;
            r_bad  <= i_evt.bad;
            r_vals <= i_store;
        end
    end

    assign o_kind  = r_kind;
    assign o_index = (r_kind == KIND_CHAN) ? r_idx : 4'd0;
    assign o_value = (r_kind == KIND_CHAN) ? r_vals[r_idx[CH_IDX_W-1:0]] : 12'd0;
    assign o_last  = (r_left == 4'd1);
    assign o_good  = r_good;
    assign o_bad   = r_bad;

endmodule

[hdl/ibus_frame_receiver_core.sv]
// Top level of the iBUS frame receiver
// Takes one serial byte per item, one item per cycle. Bytes outside a frame
// are dropped until the first header byte; a frame is 32 bytes. The closing
// byte of a frame gives either one status item (header or checksum error) or
// fourteen channel items, which leave the result register one per ready cycle
// while input bytes keep flowing. The input stalls only on the closing byte
// of a frame while the previous frame's run is still being delivered, so with
// a ready output the sustained rate is one byte per cycle. tuser carries the
// result kind (0 channel, 1 header error, 2 checksum error); tlast marks the
// last item of a frame's run. Counters in each item include that frame.
module ibus_frame_receiver_core import ibus_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side: tdata[7:0] rx_byte
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,
    // master side
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // tdata: [3:0] channel_index, [15:4] channel_value,
    //        [31:16] good_frames, [47:32] bad_frames
    output logic [47:0] o_m_tdata,
    // tuser: [1:0] kind
    output logic [1:0]  o_m_tuser,
    output logic        o_m_tlast,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0]  w_sync_first;
    logic [7:0]  w_sync_second;
    logic        w_frame_end;
    logic        w_busy;
    logic        w_accept;
    t_frame_evt  w_evt;
    t_chan_arr   w_store;
    logic [3:0]  w_index;
    logic [11:0] w_value;
    logic [15:0] w_good;
    logic [15:0] w_bad;

    assign o_s_tready = !(w_frame_end && w_busy);
    assign w_accept   = i_s_tvalid && o_s_tready;

    ibus_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_sync_first  (w_sync_first),
        .o_sync_second (w_sync_second)
    );

    ibus_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_byte        (i_s_tdata),
        .i_sync_first  (w_sync_first),
        .i_sync_second (w_sync_second),
        .o_frame_end   (w_frame_end),
        .o_evt         (w_evt),
        .o_store       (w_store)
    );

    ibus_emitter u_emitter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (w_evt),
        .i_store (w_store),
        .i_ready (i_m_tready),
        .o_busy  (w_busy),
        .o_valid (o_m_tvalid),
        .o_kind  (o_m_tuser),
        .o_index (w_index),
        .o_value (w_value),
        .o_last  (o_m_tlast),
        .o_good  (w_good),
        .o_bad   (w_bad)
    );

    assign o_m_tdata = {w_bad, w_good, w_value, w_index};

endmodule

[hdl/ibus_checker.sv]
// Port-level checker for the iBUS frame receiver, bound to the top level
`include "assert_macros.svh"

module ibus_checker import ibus_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [47:0] o_m_tdata,
    input logic [1:0]  o_m_tuser,
    input logic        o_m_tlast
);

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast), "stalled result changed")
    `ASSERT_IMPL(a_kind_code, i_clk, i_rst_n, o_m_tvalid, o_m_tuser != 2'd3, "unknown result kind")
    `ASSERT_IMPL(a_status_last, i_clk, i_rst_n, o_m_tvalid && o_m_tuser != KIND_CHAN, o_m_tlast && o_m_tdata[15:0] == 16'h0, "status item not a lone last item")
    `ASSERT_IMPL(a_chan_range, i_clk, i_rst_n, o_m_tvalid && o_m_tuser == KIND_CHAN, o_m_tdata[3:0] < 4'(NUM_CHANNELS) && (o_m_tlast == (o_m_tdata[3:0] == 4'(NUM_CHANNELS - 1))), "channel index or last flag wrong")

endmodule

bind ibus_frame_receiver_core ibus_checker u_ibus_checker (.*);

[dv/tb_ibus_frame_receiver_core.sv]
// Self-checking testbench for the iBUS frame receiver: byte stream in, result items out
`timescale 1ns / 100ps

module tb_ibus_frame_receiver_core;
    import ibus_pkg::*;

    localparam int          FRAME_BYTES = 32;
    localparam int          SUMMED_BYTES = 30;
    localparam int          STALL_LIMIT = 2000;
    localparam int          SETTLE_CYCLES = 20;
    localparam int          PHASE_BUDGET = 48;
    localparam logic [2:0]  ADDR_SYNC_FIRST = {REG_SYNC_FIRST, 2'b00};
    localparam logic [2:0]  ADDR_SYNC_SECOND = {REG_SYNC_SECOND, 2'b00};

    typedef struct packed {
        t_kind       kind;
        logic [3:0]  idx;
        logic [11:0] val;
        logic        last;
        logic [15:0] good;
        logic [15:0] bad;
    } t_chan_report;

    // one directed frame: leading hunt bytes, header, body, checksum, and an
    // optional hand-written outcome
    typedef struct packed {
        logic [7:0]  noise_byte;
        logic [3:0]  noise_len;
        logic [7:0]  hdr2;
        logic [7:0]  fill;
        logic        rand_body;
        logic        sum_bad;
        logic        typed;
        t_kind       exp_kind;
        logic [11:0] exp_val;
    } t_frame_case;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [47:0] o_m_tdata;
    logic [1:0]  o_m_tuser;
    logic        o_m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ibus_frame_receiver_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // parser mirror
    logic [7:0]  cfg_sync_first = SYNC_FIRST_RST;
    logic [7:0]  cfg_sync_second = SYNC_SECOND_RST;
    logic        in_frame_model = 1'b0;
    logic [4:0]  frame_pos = '0;
    logic        hdr_ok = 1'b0;
    logic [15:0] frame_sum = 16'hFFFF;
    logic [7:0]  low_hold = '0;
    logic [11:0] chan_vals [NUM_CHANNELS];
    logic [15:0] good_total = '0;
    logic [15:0] bad_total = '0;

    t_chan_report awaited_reports [$];
    int unsigned  reports_queued = 0;
    int unsigned  bytes_sent = 0;
    int unsigned  mismatches = 0;
    int unsigned  stall_cycles = 0;
    bit           gaps_on = 1'b1;

    t_frame_case directed_cases [7] = '{
        // hunt bytes at the bottom extreme, all-zero channels
        '{8'h00, 4'd2, 8'h40, 8'h00, 1'b0, 1'b0, 1'b1, KIND_CHAN, 12'h000},
        // hunt bytes at the top extreme, all-ones channels masked to 12 bits
        '{8'hFF, 4'd3, 8'h40, 8'hFF, 1'b0, 1'b0, 1'b1, KIND_CHAN, 12'hFFF},
        '{8'h21, 4'd1, 8'h41, 8'h12, 1'b0, 1'b0, 1'b1, KIND_HDR_ERR, 12'h000},
        '{8'h00, 4'd0, 8'h40, 8'h55, 1'b0, 1'b1, 1'b1, KIND_SUM_ERR, 12'h000},
        // both checks fail: header error wins
        '{8'h00, 4'd0, 8'h00, 8'hAA, 1'b0, 1'b1, 1'b1, KIND_HDR_ERR, 12'h000},
        '{8'h00, 4'd0, 8'h40, 8'h00, 1'b1, 1'b0, 1'b0, KIND_CHAN, 12'h000},
        '{8'h7F, 4'd1, 8'h40, 8'hA5, 1'b0, 1'b0, 1'b0, KIND_CHAN, 12'h000}
    };

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%s", msg);
    endfunction

    function automatic string fmt_report(input t_chan_report r);
        return $sformatf("kind %0d idx %0d val %03h last %0b good %0d bad %0d",
                         r.kind, r.idx, r.val, r.last, r.good, r.bad);
    endfunction

    function automatic void queue_report(input t_kind kind, input logic [3:0] idx,
                                         input logic [11:0] val, input logic last);
        t_chan_report r;
        r.kind = kind;
        r.idx  = idx;
        r.val  = val;
        r.last = last;
        r.good = good_total;
        r.bad  = bad_total;
        awaited_reports.push_back(r);
        reports_queued++;
    endfunction

    // Advance the parser mirror by one accepted byte
    task automatic parse_rx_byte(input logic [7:0] b);
        logic [15:0] rx_sum;
        if (!in_frame_model) begin
            if (b == cfg_sync_first) begin
                in_frame_model = 1'b1;
                frame_pos      = 5'd1;
                hdr_ok         = 1'b1;
                frame_sum      = 16'hFFFF - b;
                low_hold       = '0;
            end
            return;
        end
        if (frame_pos < SUMMED_BYTES)
            frame_sum = frame_sum - b;
        if (frame_pos == 5'd1) begin
            hdr_ok = (b == cfg_sync_second);
        end else if (frame_pos >= 5'd2 && frame_pos < SUMMED_BYTES) begin
            if (!frame_pos[0])
                low_hold = b;
            else
                chan_vals[(frame_pos - 5'd3) >> 1] = {b[3:0], low_hold};
        end else if (frame_pos == SUMMED_BYTES) begin
            low_hold = b;
        end
        if (frame_pos < FRAME_BYTES - 1) begin
            frame_pos++;
            return;
        end
        in_frame_model = 1'b0;
        frame_pos      = '0;
        rx_sum         = {b, low_hold};
        if (!hdr_ok) begin
            bad_total++;
            queue_report(KIND_HDR_ERR, '0, '0, 1'b1);
        end else if (frame_sum != rx_sum) begin
            bad_total++;
            queue_report(KIND_SUM_ERR, '0, '0, 1'b1);
        end else begin
            good_total++;
            for (int i = 0; i < NUM_CHANNELS; i++)
                queue_report(KIND_CHAN, 4'(i), chan_vals[i], i == NUM_CHANNELS - 1);
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        while (gaps_on && $urandom_range(99) < 16) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        do @(posedge i_clk); while (!o_s_tready);
        bytes_sent++;
        parse_rx_byte(b);
    endtask

    // Frame of `count` bytes; a full frame carries its checksum
    task automatic send_frame(input logic [7:0] hdr2, input logic [7:0] fill,
                              input bit rand_body, input bit sum_bad,
                              input int unsigned count);
        logic [7:0]  bytes [FRAME_BYTES];
        logic [15:0] sum;
        bytes[0] = cfg_sync_first;
        bytes[1] = hdr2;
        for (int i = 2; i < SUMMED_BYTES; i++)
            bytes[i] = rand_body ? 8'($urandom_range(255)) : fill;
        sum = 16'hFFFF;
        for (int i = 0; i < SUMMED_BYTES; i++)
            sum = sum - bytes[i];
        if (sum_bad)
            sum = sum ^ (16'h1 << $urandom_range(15));
        bytes[30] = sum[7:0];
        bytes[31] = sum[15:8];
        for (int i = 0; i < count; i++)
            send_byte(bytes[i]);
    endtask

    task automatic wait_for_results();
        i_s_tvalid <= 1'b0;
        while (awaited_reports.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {24'($urandom), value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_SYNC_FIRST)
            cfg_sync_first = value;
        else
            cfg_sync_second = value;
        // bus returns to idle between transfers
        @(posedge i_clk);
    endtask

    task automatic run_random_phase(input int unsigned budget);
        int unsigned start;
        int unsigned pick;
        logic [7:0]  bad_hdr;
        start = bytes_sent;
        while (bytes_sent - start < budget) begin
            pick = $urandom_range(99);
            if (pick < 68) begin
                send_frame(cfg_sync_second, '0, 1'b1, 1'b0, FRAME_BYTES);
            end else if (pick < 78) begin
                do bad_hdr = 8'($urandom_range(255)); while (bad_hdr == cfg_sync_second);
                send_frame(bad_hdr, '0, 1'b1, 1'($urandom_range(1)), FRAME_BYTES);
            end else if (pick < 88) begin
                send_frame(cfg_sync_second, '0, 1'b1, 1'b1, FRAME_BYTES);
            end else if (pick < 96) begin
                repeat ($urandom_range(6, 1)) send_byte(8'($urandom_range(255)));
            end else begin
                // cut-short frame: the next bytes get swallowed into it
                send_frame(cfg_sync_second, '0, 1'b1, 1'b0, $urandom_range(29, 2));
            end
            if ($urandom_range(99) < 6)
                wait_for_results();
        end
        while (in_frame_model)
            send_byte(8'($urandom_range(255)));
        wait_for_results();
    endtask

    // result side: random back-pressure while gaps_on is set, and checking
    always @(posedge i_clk) begin : result_check
        t_chan_report got;
        t_chan_report want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.kind = t_kind'(o_m_tuser);
            got.idx  = o_m_tdata[3:0];
            got.val  = o_m_tdata[15:4];
            got.last = o_m_tlast;
            got.good = o_m_tdata[31:16];
            got.bad  = o_m_tdata[47:32];
            if (awaited_reports.size() == 0) begin
                flag_mismatch({"unexpected item: ", fmt_report(got)});
            end else begin
                want = awaited_reports.pop_front();
                if (got !== want)
                    flag_mismatch({"expected ", fmt_report(want), " got ", fmt_report(got)});
            end
        end
        i_m_tready <= !gaps_on || $urandom_range(99) >= 16;
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        t_frame_case fc;
        int unsigned queued_prior;
        int unsigned n_new;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_m_tready <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        for (int i = 0; i < NUM_CHANNELS; i++)
            chan_vals[i] = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_cases[c]) begin
            fc = directed_cases[c];
            repeat (fc.noise_len) send_byte(fc.noise_byte);
            queued_prior = reports_queued;
            send_frame(fc.hdr2, fc.fill, fc.rand_body, fc.sum_bad, FRAME_BYTES);
            if (fc.typed) begin
                // hand-written outcome replaces the mirror's kind and value
                n_new = reports_queued - queued_prior;
                for (int k = awaited_reports.size() - n_new; k < awaited_reports.size(); k++) begin
                    awaited_reports[k].kind = fc.exp_kind;
                    awaited_reports[k].val  = fc.exp_val;
                end
            end
        end
        wait_for_results();

        run_random_phase(PHASE_BUDGET);

        write_reg(ADDR_SYNC_FIRST, 8'h00);
        write_reg(ADDR_SYNC_SECOND, 8'hFF);
        gaps_on = 1'b0;
        run_random_phase(PHASE_BUDGET);

        write_reg(ADDR_SYNC_FIRST, 8'hFF);
        write_reg(ADDR_SYNC_SECOND, 8'h00);
        gaps_on = 1'b1;
        run_random_phase(PHASE_BUDGET);

        write_reg(ADDR_SYNC_SECOND, 8'($urandom_range(255)));
        write_reg(ADDR_SYNC_FIRST, 8'($urandom_range(255)));
        run_random_phase(PHASE_BUDGET);

        if (awaited_reports.size() != 0) begin
            flag_mismatch($sformatf("%0d items never arrived", awaited_reports.size()));
            mismatches += awaited_reports.size() - 1;
        end
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[files.f]
+incdir+hdl
hdl/ibus_pkg.sv
hdl/ibus_cfg.sv
hdl/ibus_parser.sv
hdl/ibus_emitter.sv
hdl/ibus_frame_receiver_core.sv
hdl/ibus_checker.sv
dv/tb_ibus_frame_receiver_core.sv
